FILE: design/time_format_sanitizer_defines.svh
// assertion macros for the time format sanitizer checker
`ifndef TIME_FORMAT_SANITIZER_DEFINES_SVH
`define TIME_FORMAT_SANITIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TFS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("time_format_sanitizer check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TFS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("time_format_sanitizer check failed");

`endif

FILE: design/tfs_pkg.sv
// types, character constants and letter table for the time format sanitizer
package tfs_pkg;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam logic [7:0] HASH_CHAR = 8'h23;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HASH = 2'd2
  } esc_mode_t;

  function automatic logic letter_allowed(input logic [7:0] c);
    logic ok;
    case (c)
      "a", "A", "b", "B", "c", "d", "H", "I", "j", "m", "M", "p",
      "S", "U", "w", "W", "x", "X", "y", "Y", "z", "Z", "%": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: design/time_format_sanitizer.sv
// time format sanitizer: filters escapes of a format string, one byte a word
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | in_char, in_last
//   out     | out_valid / out_ready| out_char, char_valid, last_of_item,
//           |                      | end_of_string, format_error
//
// each accepted word is decoded in the cycle it is taken and loads 0 to 3 result
// words into a three-entry result shift register, drained one word per cycle
// while out_ready is high. a word that releases no character but ends the string
// loads one bare end marker word; otherwise such a word loads nothing.
// in_ready is high while the result register is empty or its final word is taken.
// rst is synchronous: escape state, error flag and result count clear.
// stalls on out hold the result register and, through in_ready, the input.
module time_format_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       last_of_item,
  output logic       end_of_string,
  output logic       format_error
);

  tfs_pkg::esc_mode_t escape_mode, escape_mode_next;
  logic       error_seen, error_next;
  logic [1:0] rem;
  logic [7:0] b0, b1, b2;
  logic       str_last, str_err, char_ok;

  logic [7:0] c0, c1, c2;
  logic [1:0] n_next, load_cnt;
  logic       bare;
  logic       in_fire, out_fire;

  assign out_valid = (rem != 2'd0);
  assign in_ready  = (rem == 2'd0) || ((rem == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    c0 = 8'h00;
    c1 = 8'h00;
    c2 = 8'h00;
    n_next = 2'd0;
    escape_mode_next = tfs_pkg::ESC_NONE;
    error_next = error_seen;
    case (escape_mode)
      tfs_pkg::ESC_PCT: begin
        if (in_char == tfs_pkg::HASH_CHAR) begin
          escape_mode_next = tfs_pkg::ESC_HASH;
        end else if (tfs_pkg::letter_allowed(in_char)) begin
          c0 = tfs_pkg::PCT_CHAR;
          c1 = in_char;
          n_next = 2'd2;
        end else begin
          error_next = 1'b1;
        end
      end
      tfs_pkg::ESC_HASH: begin
        if (tfs_pkg::letter_allowed(in_char)) begin
          c0 = tfs_pkg::PCT_CHAR;
          c1 = tfs_pkg::HASH_CHAR;
          c2 = in_char;
          n_next = 2'd3;
        end else begin
          error_next = 1'b1;
        end
      end
      default: begin
        if (in_char == tfs_pkg::PCT_CHAR) begin
          escape_mode_next = tfs_pkg::ESC_PCT;
        end else begin
          c0 = in_char;
          n_next = 2'd1;
        end
      end
    endcase
    if (in_last && (escape_mode_next != tfs_pkg::ESC_NONE)) begin
      error_next = 1'b1;
      escape_mode_next = tfs_pkg::ESC_NONE;
    end
    bare = (n_next == 2'd0) && in_last;
    load_cnt = bare ? 2'd1 : n_next;
  end

  // escape state and result count
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= tfs_pkg::ESC_NONE;
      error_seen  <= 1'b0;
      rem         <= 2'd0;
    end else begin
      if (in_fire) begin
        escape_mode <= escape_mode_next;
        error_seen  <= in_last ? 1'b0 : error_next;
        rem         <= load_cnt;
      end else if (out_fire) begin
        rem <= rem - 2'd1;
      end
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b0       <= c0;
      b1       <= c1;
      b2       <= c2;
      char_ok  <= !bare;
      str_last <= in_last;
      str_err  <= error_next;
    end else if (out_fire) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  assign out_char      = b0;
  assign char_valid    = char_ok;
  assign last_of_item  = (rem == 2'd1);
  assign end_of_string = last_of_item && str_last;
  assign format_error  = end_of_string && str_err;

endmodule

FILE: design/tfs_checker.sv
// port-level assertion checker for the time format sanitizer, with its bind
`include "time_format_sanitizer_defines.svh"

module tfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_valid,
  input logic       last_of_item,
  input logic       end_of_string,
  input logic       format_error
);

  // a stalled input word holds
  `TFS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_char) && $stable(in_last))

  // a stalled result word holds
  `TFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char))

  // end of string closes the item
  `TFS_ASSERT_NOW(a_eos_last, out_valid && end_of_string, last_of_item)

  // error is only reported on the end of string word
  `TFS_ASSERT_NOW(a_err_eos, out_valid && format_error, end_of_string)

  // a bare marker is a zero end of string word
  `TFS_ASSERT_NOW(a_bare_eos, out_valid && !char_valid, end_of_string && (out_char == 8'h00))

endmodule

bind time_format_sanitizer tfs_checker u_tfs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_char       (in_char),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char      (out_char),
  .char_valid    (char_valid),
  .last_of_item  (last_of_item),
  .end_of_string (end_of_string),
  .format_error  (format_error)
);

FILE: bench/tb_top.sv
// testbench for time_format_sanitizer: escape filtering of format strings checked word by word
`timescale 1ns / 1ps

module tb_top;

  localparam string CONVERSION_LETTERS = "aAbBcdHIjmMpSUwWxXyYzZ%";
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES = 380;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       item_end;
    logic       str_end;
    logic       err;
  } out_word_t;

  class escape_scoreboard;
    tfs_pkg::esc_mode_t mode;
    bit          dropped;
    out_word_t   pending[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned bytes_noted;
    int unsigned strings_done;
    int unsigned bad_strings;

    function new();
      mode = tfs_pkg::ESC_NONE;
      dropped = 1'b0;
    endfunction

    function bit is_conversion(logic [7:0] c);
      for (int i = 0; i < CONVERSION_LETTERS.len(); i++)
        if (CONVERSION_LETTERS[i] == c) return 1'b1;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      logic [7:0] released[$];
      out_word_t  w;
      bytes_noted++;
      case (mode)
        tfs_pkg::ESC_PCT: begin
          if (c == tfs_pkg::HASH_CHAR) begin
            mode = tfs_pkg::ESC_HASH;
          end else begin
            if (is_conversion(c)) begin
              released.push_back(tfs_pkg::PCT_CHAR);
              released.push_back(c);
            end else begin
              dropped = 1'b1;
            end
            mode = tfs_pkg::ESC_NONE;
          end
        end
        tfs_pkg::ESC_HASH: begin
          if (is_conversion(c)) begin
            released.push_back(tfs_pkg::PCT_CHAR);
            released.push_back(tfs_pkg::HASH_CHAR);
            released.push_back(c);
          end else begin
            dropped = 1'b1;
          end
          mode = tfs_pkg::ESC_NONE;
        end
        default: begin
          if (c == tfs_pkg::PCT_CHAR) mode = tfs_pkg::ESC_PCT;
          else released.push_back(c);
        end
      endcase
      // open escape at end of string is dropped
      if (last && mode != tfs_pkg::ESC_NONE) begin
        dropped = 1'b1;
        mode = tfs_pkg::ESC_NONE;
      end
      if (released.size() == 0 && last) begin
        w = out_word_t'{8'h00, 1'b0, 1'b1, 1'b1, dropped};
        pending.push_back(w);
      end
      foreach (released[k]) begin
        w.ch       = released[k];
        w.ch_valid = 1'b1;
        w.item_end = (k == released.size() - 1);
        w.str_end  = w.item_end && last;
        w.err      = w.str_end ? dropped : 1'b0;
        pending.push_back(w);
      end
      if (last) begin
        strings_done++;
        if (dropped) bad_strings++;
        dropped = 1'b0;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      words_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual char %h valid %b",
                 $time, got.ch, got.ch_valid);
        $display("    item_end %b str_end %b err %b", got.item_end, got.str_end, got.err);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        mismatches++;
        $display("%0t: mismatch: expected char %h valid %b item_end %b str_end %b err %b",
                 $time, want.ch, want.ch_valid, want.item_end, want.str_end, want.err);
        $display("    actual char %h valid %b item_end %b str_end %b err %b",
                 got.ch, got.ch_valid, got.item_end, got.str_end, got.err);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last_of_item;
  logic       end_of_string;
  logic       format_error;

  escape_scoreboard book = new();
  int unsigned in_idle_pct = 31;
  int unsigned out_idle_pct = 31;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  time_format_sanitizer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char       (in_char),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .last_of_item  (last_of_item),
    .end_of_string (end_of_string),
    .format_error  (format_error)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) book.note_byte(in_char, in_last);
      if (out_valid && out_ready)
        book.check_word(out_word_t'{out_char, char_valid, last_of_item, end_of_string,
                                    format_error});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_char  = c;
    in_last  = last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (book.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_string();
    logic [7:0] q[$];
    int unsigned tokens;
    int unsigned kind;
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        q.push_back(tfs_pkg::PCT_CHAR);
        if ($urandom_range(0, 99) < 40) q.push_back(tfs_pkg::HASH_CHAR);
        if ($urandom_range(0, 99) < 80)
          q.push_back(CONVERSION_LETTERS[$urandom_range(0, CONVERSION_LETTERS.len() - 1)]);
        else
          q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 85) begin
        q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 93) begin
        q.push_back(tfs_pkg::PCT_CHAR);
      end else begin
        q.push_back(tfs_pkg::PCT_CHAR);
        q.push_back(tfs_pkg::HASH_CHAR);
      end
    end
    send_bytes(q);
  endtask

  initial begin
    logic [7:0] edge_bytes[$];
    bit paused;
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_char   = 8'h01;
    in_last   = 1'b0;
    out_ready = 1'b0;
    paused    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text("%a");
    send_text("%#Y");
    send_text("%%");
    send_text("%#%");
    send_text("%##");
    send_text("%q");
    send_text("x%");
    send_text("%#");
    send_text("%");
    edge_bytes = {8'hFF, 8'h01};
    send_bytes(edge_bytes);
    edge_bytes = {tfs_pkg::PCT_CHAR, 8'hFF};
    send_bytes(edge_bytes);

    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= 150 && bytes_sent < 260) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 31;
        out_idle_pct = 31;
      end
      if (!paused && bytes_sent >= 200) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_string();
    end

    wait_drained();
    repeat (12) @(negedge clk);
    $display("sent %0d bytes in %0d strings (%0d with dropped escapes), checked %0d words",
             book.bytes_noted, book.strings_done, book.bad_strings, book.words_checked);
    if (book.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
